// ===== rtl/core/ssm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge package
// Shared types and codes for the sorted set merge block.
// ----------------------------------------------------------------------------
package ssm_pkg;

	typedef enum logic [1:0] {
		ACT_APPEND_A = 2'd0,
		ACT_APPEND_B = 2'd1,
		ACT_RUN      = 2'd2,
		ACT_CLEAR    = 2'd3
	} ssm_action_t;

	// Set operation codes held in the configuration register.
	localparam logic [1:0] OP_UNION = 2'd0;
	localparam logic [1:0] OP_DIFF  = 2'd1;
	localparam logic [1:0] OP_INTER = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} ssm_state_t;

	typedef struct packed {
		logic app_a;
		logic app_b;
		logic clear;
		logic adv_a;
		logic adv_b;
		logic emit;
		logic emit_b;
		logic finish;
	} ssm_cmd_t;

	typedef struct packed {
		logic a_ok;
		logic b_ok;
		logic a_lt_b;
		logic b_lt_a;
		logic slot_free;
	} ssm_stat_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               last;
		logic               empty_res;
		logic               overflow;
		logic               order_error;
	} ssm_res_t;

endpackage

// ===== rtl/core/ssm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge input channel
// Valid/ready channel carrying one action and its element value.
// ----------------------------------------------------------------------------
interface ssm_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  action;
	logic signed [31:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== rtl/core/ssm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge result channel
// Valid/ready channel carrying one result element and its status flags.
// ----------------------------------------------------------------------------
interface ssm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               last;
	logic               empty_res;
	logic               overflow;
	logic               order_error;

	modport source (output valid, output result_value, output last, output empty_res,
		output overflow, output order_error, input ready);
	modport sink   (input valid, input result_value, input last, input empty_res,
		input overflow, input order_error, output ready);
endinterface

// ===== rtl/core/sorted_set_merge_ops.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge unit
// Loads two ascending sets and merges them as union, A minus B or
// intersection.
// ----------------------------------------------------------------------------
// Usage: items carries an action and a value. Append to A or B and clear
// give no transfer on results; appends are taken one per cycle. A run item
// starts a merge of both sets in the mode held in the set operation register
// (cfg_we, cfg_data), which must be written only while idle by the user; the
// block does not enforce this. The merge makes one two-pointer step per cycle
// while the output register is free, and items is not ready during a run.
// Each result is held back until the next result or the end of the run
// pushes it into the output register. The final transfer carries last; an
// empty result gives a single transfer with empty_res and last set.
// Every transfer carries the sticky overflow and order flags. A run empties
// both sets, a clear also resets the flags.
// When results is stalled, the merge waits on its output register and no
// data is lost; a new item is taken as soon as the run's last result sits in
// that register. Reset empties both sets, clears the flags and selects union.
// ----------------------------------------------------------------------------
module sorted_set_merge_ops
	import ssm_pkg::*;
#(
	parameter int SET_DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_data,
	ssm_in_if.sink          items,
	ssm_out_if.source       results
);

	ssm_cmd_t  cmd;
	ssm_stat_t stat;
	ssm_res_t  res;

	ssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (items.valid),
		.action   (items.action),
		.in_ready (items.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssm_datapath #(
		.SET_DEPTH (SET_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (items.value),
		.out_ready (results.ready),
		.stat      (stat),
		.out_valid (results.valid),
		.out_item  (res)
	);

	assign results.result_value = res.result_value;
	assign results.last         = res.last;
	assign results.empty_res    = res.empty_res;
	assign results.overflow     = res.overflow;
	assign results.order_error  = res.order_error;

endmodule

// ===== rtl/core/ssm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge datapath
// Set stores, counts, merge pointers, held result and output register.
// ----------------------------------------------------------------------------
module ssm_datapath
	import ssm_pkg::*;
#(
	parameter int SET_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssm_cmd_t           cmd,
	input  logic signed [31:0] value,
	input  logic               out_ready,
	output ssm_stat_t          stat,
	output logic               out_valid,
	output ssm_res_t           out_item
);

	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

	logic signed [31:0] set_a_mem [SET_DEPTH];
	logic signed [31:0] set_b_mem [SET_DEPTH];

	logic        [CW-1:0] cnt_a_q, cnt_b_q;
	logic        [CW-1:0] idx_a_q, idx_b_q;
	logic        [CW-1:0] idx_a_nxt, idx_b_nxt;
	logic signed [31:0]   last_a_q, last_b_q;
	logic signed [31:0]   head_a_q, head_b_q;
	logic signed [31:0]   pend_q;
	logic                 pend_vld_q;
	logic                 ovf_q, ord_q;
	logic                 out_vld_q;
	ssm_res_t             out_q;
	logic signed [31:0]   emit_val;
	logic                 push;
	logic                 wr_a, wr_b;

	assign wr_a = cmd.app_a && (cnt_a_q != DEPTH_C);
	assign wr_b = cmd.app_b && (cnt_b_q != DEPTH_C);

	// The read address runs one element ahead when a pointer advances, so the
	// head registers always hold the element under each pointer.
	assign idx_a_nxt = cmd.adv_a ? idx_a_q + CW'(1) : idx_a_q;
	assign idx_b_nxt = cmd.adv_b ? idx_b_q + CW'(1) : idx_b_q;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			set_a_mem[cnt_a_q[AW-1:0]] <= value;
		end
		if (wr_b) begin
			set_b_mem[cnt_b_q[AW-1:0]] <= value;
		end
		head_a_q <= set_a_mem[idx_a_nxt[AW-1:0]];
		head_b_q <= set_b_mem[idx_b_nxt[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			idx_a_q    <= '0;
			idx_b_q    <= '0;
			ovf_q      <= 1'b0;
			ord_q      <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cmd.app_a) begin
				if (!wr_a) begin
					ovf_q <= 1'b1;
				end else begin
					if (cnt_a_q != '0 && !(last_a_q < value)) begin
						ord_q <= 1'b1;
					end
					cnt_a_q <= cnt_a_q + CW'(1);
				end
			end
			if (cmd.app_b) begin
				if (!wr_b) begin
					ovf_q <= 1'b1;
				end else begin
					if (cnt_b_q != '0 && !(last_b_q < value)) begin
						ord_q <= 1'b1;
					end
					cnt_b_q <= cnt_b_q + CW'(1);
				end
			end
			idx_a_q <= idx_a_nxt;
			idx_b_q <= idx_b_nxt;
			if (cmd.emit) begin
				pend_vld_q <= 1'b1;
			end
			if (cmd.finish) begin
				cnt_a_q    <= '0;
				cnt_b_q    <= '0;
				idx_a_q    <= '0;
				idx_b_q    <= '0;
				pend_vld_q <= 1'b0;
			end
			if (cmd.clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				ovf_q   <= 1'b0;
				ord_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			last_a_q <= value;
		end
		if (wr_b) begin
			last_b_q <= value;
		end
		if (cmd.emit) begin
			pend_q <= emit_val;
		end
	end

	assign emit_val = cmd.emit_b ? head_b_q : head_a_q;

	// A result is held back by one step so that the final one can be marked.
	assign push = (cmd.emit && pend_vld_q) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q.result_value <= pend_vld_q ? pend_q : 32'sd0;
			out_q.last         <= cmd.finish;
			out_q.empty_res    <= cmd.finish && !pend_vld_q;
			out_q.overflow     <= ovf_q;
			out_q.order_error  <= ord_q;
		end
	end

	assign stat.a_ok      = idx_a_q < cnt_a_q;
	assign stat.b_ok      = idx_b_q < cnt_b_q;
	assign stat.a_lt_b    = head_a_q < head_b_q;
	assign stat.b_lt_a    = head_b_q < head_a_q;
	assign stat.slot_free = !out_vld_q || out_ready;

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

endmodule

// ===== rtl/core/ssm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge controller
// Accepts actions, holds the set operation and steps the merge.
// ----------------------------------------------------------------------------
module ssm_ctrl
	import ssm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	input  logic [1:0] action,
	output logic       in_ready,
	input  ssm_stat_t  stat,
	output ssm_cmd_t   cmd
);

	ssm_state_t state_q, state_nxt;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_UNION;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				op_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						ACT_APPEND_A: cmd.app_a = 1'b1;
						ACT_APPEND_B: cmd.app_b = 1'b1;
						ACT_RUN:      state_nxt = ST_MERGE;
						ACT_CLEAR:    cmd.clear = 1'b1;
						default:      cmd.clear = 1'b0;
					endcase
				end
			end
			ST_MERGE: begin
				// One two-pointer step per cycle while the output slot is free.
				if (stat.slot_free) begin
					if (op_q != OP_UNION && op_q != OP_DIFF && op_q != OP_INTER) begin
						cmd.finish = 1'b1;
					end else if (stat.a_ok && stat.b_ok) begin
						if (stat.a_lt_b) begin
							cmd.adv_a = 1'b1;
							cmd.emit  = (op_q != OP_INTER);
						end else if (stat.b_lt_a) begin
							cmd.adv_b  = 1'b1;
							cmd.emit   = (op_q == OP_UNION);
							cmd.emit_b = 1'b1;
						end else begin
							cmd.adv_a = 1'b1;
							cmd.adv_b = 1'b1;
							cmd.emit  = (op_q != OP_DIFF);
						end
					end else if (stat.a_ok && op_q != OP_INTER) begin
						cmd.adv_a = 1'b1;
						cmd.emit  = 1'b1;
					end else if (stat.b_ok && op_q == OP_UNION) begin
						cmd.adv_b  = 1'b1;
						cmd.emit   = 1'b1;
						cmd.emit_b = 1'b1;
					end else begin
						cmd.finish = 1'b1;
					end
					if (cmd.finish) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule
